// ===== hw/rtl/rumble_effect_mixer_defines.svh =====
// Assertion macros for the rumble effect mixer.
// Included by the top level; no other dependencies.
`ifndef RUMBLE_EFFECT_MIXER_DEFINES_SVH
`define RUMBLE_EFFECT_MIXER_DEFINES_SVH

`ifndef SYNTHESIS
`define REM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define REM_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define REM_ASSERT(lbl, prop, msg)
`define REM_ASSERT_RST(lbl, prop, msg)
`endif

`endif

// ===== hw/rtl/rem_pkg.sv =====
// Shared types, constants and helpers for the rumble effect mixer.
// No dependencies; imported by rumble_effect_mixer.
`timescale 1ns / 1ps

package rem_pkg;

  localparam int unsigned PAD_COUNT     = 4;
  localparam int unsigned SLOTS_PER_PAD = 8;
  localparam int unsigned TOTAL_SLOTS   = PAD_COUNT * SLOTS_PER_PAD;

  localparam int unsigned PAD_W  = 2;
  localparam int unsigned SUB_W  = (SLOTS_PER_PAD > 1) ? $clog2(SLOTS_PER_PAD) : 1;
  localparam int unsigned SLOT_W = (TOTAL_SLOTS > 1) ? $clog2(TOTAL_SLOTS) : 1;

  localparam logic [31:0] FOREVER_US = 32'hFFFF_FFFF;
  localparam logic [15:0] FULL_SCALE = 16'hFFFF;

  typedef enum logic [1:0] {
    MODE_TICK = 2'd0,
    MODE_ADD  = 2'd1,
    MODE_SET  = 2'd2
  } mode_e;

  typedef struct packed {
    logic [15:0] left;
    logic [15:0] right;
    logic [31:0] remaining;
  } slot_t;

  function automatic logic [15:0] sat_add16(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[16] ? FULL_SCALE : s[15:0];
  endfunction

endpackage

// ===== hw/rtl/rumble_effect_mixer.sv =====
// Rumble effect mixer: per-controller table of timed effects and motor-speed mixing.
// Depends on rem_pkg and rumble_effect_mixer_defines.svh.
//
//   channel   direction   handshake                 carries
//   cfg       in          cfg_valid_i/cfg_ready_o   pad_connected mask
//   in        in          in_valid_i/in_ready_o     mode, pad, strengths, times
//   out       out         out_valid_o/out_ready_i   pad, left/right speed, last
//
// An add or set item finishes in the cycle it is accepted.
// A tick item walks every slot, reading it from slot memory and then aging and summing it,
// and emits one result per controller after that controller's slots.
// A waiting result holds the tick walk; the output register frees the input side.
// Reset empties the table at once through per-slot valid bits; no clearing pass.
`timescale 1ns / 1ps

`include "rumble_effect_mixer_defines.svh"

module rumble_effect_mixer (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [3:0]               cfg_pad_connected_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [1:0]               mode_i,
  input  logic [rem_pkg::PAD_W-1:0] pad_index_i,
  input  logic [15:0]              left_strength_i,
  input  logic [15:0]              right_strength_i,
  input  logic [31:0]              effect_duration_us_i,
  input  logic [23:0]              elapsed_us_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [rem_pkg::PAD_W-1:0] out_pad_o,
  output logic [15:0]              left_speed_o,
  output logic [15:0]              right_speed_o,
  output logic                     last_pad_o
);

  import rem_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_READ = 4'b0010,
    ST_AGE  = 4'b0100,
    ST_EMIT = 4'b1000
  } state_e;

  localparam logic [SUB_W-1:0] SUB_LAST = SUB_W'(SLOTS_PER_PAD - 1);
  localparam logic [PAD_W-1:0] PAD_LAST = PAD_W'(PAD_COUNT - 1);

  state_e                   state_q, state_d;
  logic [3:0]               pad_connected_q;
  logic [TOTAL_SLOTS-1:0]   slot_valid_q, slot_valid_d;
  slot_t                    slot_mem [TOTAL_SLOTS];
  slot_t                    rd_data_q;
  logic                     mem_we;
  logic [SLOT_W-1:0]        mem_waddr;
  slot_t                    mem_wdata;
  logic [23:0]              elapsed_q;
  logic [PAD_W-1:0]         pad_q, pad_d;
  logic [SUB_W-1:0]         sub_q, sub_d;
  logic [SLOT_W-1:0]        slot_q, slot_d;
  logic [15:0]              sum_left_q, sum_left_d;
  logic [15:0]              sum_right_q, sum_right_d;
  logic                     out_valid_q, out_valid_d;
  logic                     out_load;
  logic [PAD_W-1:0]         out_pad_q;
  logic [15:0]              left_speed_q, right_speed_q;
  logic                     last_pad_q;

  logic                     in_accept;
  logic                     pad_usable;
  logic [SLOT_W-1:0]        pad_base;
  logic                     free_found;
  logic [SUB_W-1:0]         free_sub;
  logic [32:0]              age_diff;
  logic                     is_forever;
  logic                     expired;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign in_accept   = in_valid_i && in_ready_o;

  assign pad_usable = ({1'b0, pad_index_i} < (PAD_W + 1)'(PAD_COUNT))
                      && pad_connected_q[pad_index_i];
  assign pad_base   = SLOT_W'(pad_index_i) * SLOT_W'(SLOTS_PER_PAD);

  always_comb begin
    free_found = 1'b0;
    free_sub   = '0;
    for (int i = SLOTS_PER_PAD - 1; i >= 0; i--) begin
      if (!slot_valid_q[pad_base + SLOT_W'(i)]) begin
        free_found = 1'b1;
        free_sub   = SUB_W'(i);
      end
    end
  end

  // Shared aging unit: one subtract gives both the expiry test and the new time.
  assign age_diff   = {1'b0, rd_data_q.remaining} - {9'b0, elapsed_q};
  assign is_forever = (rd_data_q.remaining == FOREVER_US);
  assign expired    = age_diff[32] || (age_diff[31:0] == 32'd0);

  always_comb begin
    state_d      = state_q;
    slot_valid_d = slot_valid_q;
    mem_we       = 1'b0;
    mem_waddr    = slot_q;
    mem_wdata    = rd_data_q;
    pad_d        = pad_q;
    sub_d        = sub_q;
    slot_d       = slot_q;
    sum_left_d   = sum_left_q;
    sum_right_d  = sum_right_q;
    out_load     = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          unique case (mode_i)
            MODE_ADD: begin
              if (pad_usable && free_found) begin
                mem_we                  = 1'b1;
                mem_waddr               = pad_base + SLOT_W'(free_sub);
                mem_wdata.left          = left_strength_i;
                mem_wdata.right         = right_strength_i;
                mem_wdata.remaining     = effect_duration_us_i;
                slot_valid_d[mem_waddr] = 1'b1;
              end
            end
            MODE_SET: begin
              if (pad_usable) begin
                for (int i = 0; i < SLOTS_PER_PAD; i++) begin
                  slot_valid_d[pad_base + SLOT_W'(i)] = 1'b0;
                end
                if ((left_strength_i != 16'd0) || (right_strength_i != 16'd0)) begin
                  mem_we                 = 1'b1;
                  mem_waddr              = pad_base;
                  mem_wdata.left         = left_strength_i;
                  mem_wdata.right        = right_strength_i;
                  mem_wdata.remaining    = FOREVER_US;
                  slot_valid_d[pad_base] = 1'b1;
                end
              end
            end
            MODE_TICK: begin
              state_d     = ST_READ;
              pad_d       = '0;
              sub_d       = '0;
              slot_d      = '0;
              sum_left_d  = '0;
              sum_right_d = '0;
            end
            default: begin
            end
          endcase
        end
      end
      ST_READ: begin
        state_d = ST_AGE;
      end
      ST_AGE: begin
        if (slot_valid_q[slot_q]) begin
          if (!is_forever && expired) begin
            slot_valid_d[slot_q] = 1'b0;
          end else begin
            if (!is_forever) begin
              mem_we              = 1'b1;
              mem_wdata.remaining = age_diff[31:0];
            end
            sum_left_d  = sat_add16(sum_left_q, rd_data_q.left);
            sum_right_d = sat_add16(sum_right_q, rd_data_q.right);
          end
        end
        if (sub_q == SUB_LAST) begin
          state_d = ST_EMIT;
        end else begin
          state_d = ST_READ;
          sub_d   = sub_q + 1'b1;
          slot_d  = slot_q + 1'b1;
        end
      end
      ST_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          out_load    = 1'b1;
          sum_left_d  = '0;
          sum_right_d = '0;
          if (pad_q == PAD_LAST) begin
            state_d = ST_IDLE;
          end else begin
            state_d = ST_READ;
            pad_d   = pad_q + 1'b1;
            sub_d   = '0;
            slot_d  = slot_q + 1'b1;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= ST_IDLE;
      pad_connected_q <= '0;
      slot_valid_q    <= '0;
      pad_q           <= '0;
      sub_q           <= '0;
      slot_q          <= '0;
      sum_left_q      <= '0;
      sum_right_q     <= '0;
      out_valid_q     <= 1'b0;
    end else begin
      state_q      <= state_d;
      slot_valid_q <= slot_valid_d;
      pad_q        <= pad_d;
      sub_q        <= sub_d;
      slot_q       <= slot_d;
      sum_left_q   <= sum_left_d;
      sum_right_q  <= sum_right_d;
      out_valid_q  <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        pad_connected_q <= cfg_pad_connected_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      slot_mem[mem_waddr] <= mem_wdata;
    end
    rd_data_q <= slot_mem[slot_q];
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      elapsed_q <= elapsed_us_i;
    end
    if (out_load) begin
      out_pad_q     <= pad_q;
      left_speed_q  <= sum_left_q;
      right_speed_q <= sum_right_q;
      last_pad_q    <= (pad_q == PAD_LAST);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_pad_o     = out_pad_q;
  assign left_speed_o  = left_speed_q;
  assign right_speed_o = right_speed_q;
  assign last_pad_o    = last_pad_q;

  `REM_ASSERT(a_tick_busy, (in_valid_i && in_ready_o && mode_i == MODE_TICK) |=> !in_ready_o, "tick item did not start the slot walk")
  `REM_ASSERT(a_add_done, (in_valid_i && in_ready_o && mode_i == MODE_ADD) |=> in_ready_o, "add item did not finish in one cycle")
  `REM_ASSERT(a_last_pad, (out_valid_o && last_pad_o) |-> (out_pad_o == PAD_LAST), "last result marked on wrong controller")
  `REM_ASSERT_RST(a_reset_out, !rst_ni |=> (!out_valid_o && in_ready_o), "block not idle after reset")

endmodule

// ===== bench/rumble_effect_mixer_tb.sv =====
// Self-checking testbench for rumble_effect_mixer: directed and random effect items,
// with a built-in table predictor and random idling on both channels.
// Depends on rem_pkg and the rumble_effect_mixer RTL.
`timescale 1ns / 1ps

module rumble_effect_mixer_tb;
  import rem_pkg::*;

  localparam logic [1:0] MODE_NONE = 2'd3;

  typedef struct packed {
    logic [1:0]       mode;
    logic [PAD_W-1:0] pad;
    logic [15:0]      left;
    logic [15:0]      right;
    logic [31:0]      dur;
    logic [23:0]      elapsed;
  } rumble_item_t;

  typedef struct packed {
    logic [PAD_W-1:0] pad;
    logic [15:0]      left;
    logic [15:0]      right;
    logic             last;
  } motor_speed_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_valid_i = 1'b0;
  logic             cfg_ready_o;
  logic [3:0]       cfg_pad_connected_i = 4'h0;
  logic             in_valid_i = 1'b0;
  logic             in_ready_o;
  logic [1:0]       mode_i;
  logic [PAD_W-1:0] pad_index_i;
  logic [15:0]      left_strength_i;
  logic [15:0]      right_strength_i;
  logic [31:0]      effect_duration_us_i;
  logic [23:0]      elapsed_us_i;
  logic             out_valid_o;
  logic             out_ready_i = 1'b0;
  logic [PAD_W-1:0] out_pad_o;
  logic [15:0]      left_speed_o;
  logic [15:0]      right_speed_o;
  logic             last_pad_o;

  rumble_item_t shown = '0;
  rumble_item_t next_item;
  rumble_item_t pending_items[$];
  motor_speed_t speed_due[$];
  motor_speed_t got_speed;
  motor_speed_t want_speed;

  logic [3:0]  mask_model = 4'h0;
  logic        slot_live [TOTAL_SLOTS];
  logic [15:0] slot_l    [TOTAL_SLOTS];
  logic [15:0] slot_r    [TOTAL_SLOTS];
  logic [31:0] slot_time [TOTAL_SLOTS];

  int unsigned idle_pct = 15;
  int unsigned src_gap = 0;
  int unsigned sink_gap = 0;
  int unsigned hold_left = 0;
  logic        long_hold_go = 1'b0;
  int          err_cnt = 0;

  assign mode_i               = shown.mode;
  assign pad_index_i          = shown.pad;
  assign left_strength_i      = shown.left;
  assign right_strength_i     = shown.right;
  assign effect_duration_us_i = shown.dur;
  assign elapsed_us_i         = shown.elapsed;

  rumble_effect_mixer dut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_valid_i          (cfg_valid_i),
    .cfg_ready_o          (cfg_ready_o),
    .cfg_pad_connected_i  (cfg_pad_connected_i),
    .in_valid_i           (in_valid_i),
    .in_ready_o           (in_ready_o),
    .mode_i               (mode_i),
    .pad_index_i          (pad_index_i),
    .left_strength_i      (left_strength_i),
    .right_strength_i     (right_strength_i),
    .effect_duration_us_i (effect_duration_us_i),
    .elapsed_us_i         (elapsed_us_i),
    .out_valid_o          (out_valid_o),
    .out_ready_i          (out_ready_i),
    .out_pad_o            (out_pad_o),
    .left_speed_o         (left_speed_o),
    .right_speed_o        (right_speed_o),
    .last_pad_o           (last_pad_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    for (int i = 0; i < TOTAL_SLOTS; i++) begin
      slot_live[i] = 1'b0;
    end
  end

  function automatic void store_rumble(input int pad, input logic [15:0] l,
                                       input logic [15:0] r, input logic [31:0] t);
    int  k;
    bit  placed;
    placed = 1'b0;
    for (int s = 0; s < SLOTS_PER_PAD; s++) begin
      k = pad * SLOTS_PER_PAD + s;
      if (!placed && !slot_live[k]) begin
        slot_live[k] = 1'b1;
        slot_l[k]    = l;
        slot_r[k]    = r;
        slot_time[k] = t;
        placed       = 1'b1;
      end
    end
  endfunction

  function automatic void apply_rumble_item(input rumble_item_t it);
    int unsigned  sum_l;
    int unsigned  sum_r;
    int           k;
    int           p;
    int           s;
    motor_speed_t res;
    case (it.mode)
      MODE_ADD: begin
        if (it.pad < PAD_COUNT && mask_model[it.pad]) begin
          store_rumble(int'(it.pad), it.left, it.right, it.dur);
        end
      end
      MODE_SET: begin
        if (it.pad < PAD_COUNT && mask_model[it.pad]) begin
          for (s = 0; s < SLOTS_PER_PAD; s++) begin
            slot_live[it.pad * SLOTS_PER_PAD + s] = 1'b0;
          end
          if (it.left != 16'h0 || it.right != 16'h0) begin
            store_rumble(int'(it.pad), it.left, it.right, FOREVER_US);
          end
        end
      end
      MODE_TICK: begin
        for (p = 0; p < PAD_COUNT; p++) begin
          sum_l = 0;
          sum_r = 0;
          for (s = 0; s < SLOTS_PER_PAD; s++) begin
            k = p * SLOTS_PER_PAD + s;
            if (slot_live[k]) begin
              if (slot_time[k] != FOREVER_US && slot_time[k] <= 32'(it.elapsed)) begin
                slot_live[k] = 1'b0;
              end else begin
                if (slot_time[k] != FOREVER_US) begin
                  slot_time[k] = slot_time[k] - 32'(it.elapsed);
                end
                sum_l += 32'(slot_l[k]);
                sum_r += 32'(slot_r[k]);
              end
            end
          end
          res.pad   = p[PAD_W-1:0];
          res.left  = (sum_l > FULL_SCALE) ? FULL_SCALE : sum_l[15:0];
          res.right = (sum_r > FULL_SCALE) ? FULL_SCALE : sum_r[15:0];
          res.last  = (p == PAD_COUNT - 1);
          speed_due.insert(speed_due.size(), res);
        end
      end
      default: begin
      end
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      src_gap    <= 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        apply_rumble_item(shown);
      end
      if (!in_valid_i || in_ready_o) begin
        if (src_gap != 0) begin
          src_gap    <= src_gap - 1;
          in_valid_i <= 1'b0;
        end else if (pending_items.size() == 0) begin
          in_valid_i <= 1'b0;
        end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
          src_gap    <= $urandom_range(0, 18);
          in_valid_i <= 1'b0;
        end else begin
          next_item = pending_items.pop_front();
          shown      <= next_item;
          in_valid_i <= 1'b1;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (long_hold_go) begin
      hold_left <= 600;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      sink_gap    <= 0;
    end else if (hold_left != 0) begin
      out_ready_i <= 1'b0;
    end else if (sink_gap != 0) begin
      sink_gap    <= sink_gap - 1;
      out_ready_i <= 1'b0;
    end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      sink_gap    <= $urandom_range(0, 18);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      got_speed = {out_pad_o, left_speed_o, right_speed_o, last_pad_o};
      if (speed_due.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10) begin
          $display("unexpected result: pad %0d left %h right %h last %b",
                   got_speed.pad, got_speed.left, got_speed.right, got_speed.last);
        end
      end else begin
        want_speed = speed_due.pop_front();
        if (got_speed !== want_speed) begin
          err_cnt++;
          if (err_cnt <= 10) begin
            $display("mismatch: expected pad %0d left %h right %h last %b",
                     want_speed.pad, want_speed.left, want_speed.right, want_speed.last);
            $display("          actual   pad %0d left %h right %h last %b",
                     got_speed.pad, got_speed.left, got_speed.right, got_speed.last);
          end
        end
      end
    end
  end

  function automatic void queue_item(input logic [1:0] mode, input logic [PAD_W-1:0] pad,
                                     input logic [15:0] l, input logic [15:0] r,
                                     input logic [31:0] dur, input logic [23:0] elapsed);
    rumble_item_t it;
    it.mode    = mode;
    it.pad     = pad;
    it.left    = l;
    it.right   = r;
    it.dur     = dur;
    it.elapsed = elapsed;
    pending_items.insert(pending_items.size(), it);
  endfunction

  task automatic queue_random(input int n);
    rumble_item_t it;
    int unsigned  r;
    repeat (n) begin
      r = $urandom_range(0, 99);
      it.mode = (r < 30) ? MODE_TICK : (r < 72) ? MODE_ADD : (r < 93) ? MODE_SET : MODE_NONE;
      it.pad = PAD_W'($urandom_range(0, 3));
      if (mask_model != 4'h0 && $urandom_range(0, 4) != 0) begin
        while (!mask_model[it.pad]) it.pad = PAD_W'($urandom_range(0, 3));
      end
      r = $urandom_range(0, 9);
      it.left = (r == 0) ? 16'h0 : (r == 1) ? FULL_SCALE :
                (r == 2) ? 16'($urandom_range(0, 4095)) : 16'($urandom);
      r = $urandom_range(0, 9);
      it.right = (r == 0) ? 16'h0 : (r == 1) ? FULL_SCALE :
                 (r == 2) ? 16'($urandom_range(0, 4095)) : 16'($urandom);
      if (it.mode == MODE_SET && $urandom_range(0, 6) == 0) begin
        it.left  = 16'h0;
        it.right = 16'h0;
      end
      r = $urandom_range(0, 9);
      it.dur = (r == 0) ? FOREVER_US : (r == 1) ? 32'd0 :
               (r == 2) ? 32'($urandom) : 32'($urandom_range(1, 20000));
      r = $urandom_range(0, 19);
      it.elapsed = (r == 0) ? 24'hFF_FFFF : (r < 3) ? 24'd0 :
                   (r < 5) ? 24'($urandom) : 24'($urandom_range(1, 4000));
      pending_items.insert(pending_items.size(), it);
    end
  endtask

  task automatic wait_drained();
    @(posedge clk_i);
    while (pending_items.size() != 0 || in_valid_i || speed_due.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_mask(input logic [3:0] m);
    wait_drained();
    cfg_valid_i         <= 1'b1;
    cfg_pad_connected_i <= m;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    mask_model = m;
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Nothing is connected: add and set are dropped, tick still reports.
    write_mask(4'h0);
    queue_item(MODE_ADD, 2'd1, 16'h1234, 16'h5678, 32'd500, 24'd0);
    queue_item(MODE_SET, 2'd2, 16'hFFFF, 16'hFFFF, 32'd0, 24'd0);
    queue_item(MODE_TICK, 2'd0, 16'h0, 16'h0, 32'd0, 24'd10);

    write_mask(4'hF);
    queue_item(MODE_ADD, 2'd0, 16'hFFFF, 16'h0000, FOREVER_US, 24'd0);
    queue_item(MODE_ADD, 2'd0, 16'h0001, 16'hFFFF, 32'd0, 24'd0);
    queue_item(MODE_ADD, 2'd0, 16'h8000, 16'h8000, 32'd1000, 24'd0);
    queue_item(MODE_TICK, 2'd0, 16'h0, 16'h0, 32'd0, 24'd0);
    queue_item(MODE_TICK, 2'd0, 16'h0, 16'h0, 32'd0, 24'd999);
    queue_item(MODE_TICK, 2'd0, 16'h0, 16'h0, 32'd0, 24'd1);
    // Nine adds to one controller: the last finds the table full.
    repeat (9) queue_item(MODE_ADD, 2'd3, 16'h1000, 16'h0F00, 32'd100, 24'd0);
    queue_item(MODE_TICK, 2'd0, 16'h0, 16'h0, 32'd0, 24'd10);
    queue_item(MODE_TICK, 2'd0, 16'h0, 16'h0, 32'd0, 24'hFF_FFFF);
    queue_item(MODE_SET, 2'd0, 16'h0000, 16'h0000, 32'd0, 24'd0);
    queue_item(MODE_SET, 2'd1, 16'hFFFF, 16'hFFFF, 32'd0, 24'd0);
    queue_item(MODE_SET, 2'd2, 16'h0000, 16'h0001, 32'd0, 24'd0);
    queue_item(MODE_NONE, 2'd3, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 24'hFF_FFFF);
    queue_item(MODE_TICK, 2'd0, 16'h0, 16'h0, 32'd0, 24'd0);

    write_mask(4'h5);
    idle_pct = 20;
    queue_random(60);

    write_mask(4'hA);
    idle_pct = 5;
    queue_random(40);
    wait_drained();
    queue_random(15);

    write_mask(4'($urandom_range(1, 14)));
    idle_pct = 40;
    queue_random(45);

    write_mask(4'h0);
    idle_pct = 10;
    queue_random(12);

    // Hold the result side off while ticks keep arriving.
    write_mask(4'hF);
    long_hold_go <= 1'b1;
    @(posedge clk_i);
    long_hold_go <= 1'b0;
    repeat (12) queue_item(MODE_TICK, 2'd0, 16'h0, 16'h0, 32'd0, 24'($urandom_range(0, 50)));
    queue_random(50);

    write_mask(4'h3);
    idle_pct = 0;
    queue_random(60);

    wait_drained();
    repeat (100) @(posedge clk_i);
    if (err_cnt == 0 && speed_due.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
